/* rtl/qph_pkg.sv */
// ----------------------------------------------------------------------------
// qph_pkg
// Shared types and constants for the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

	localparam int KEY_W      = 32;  // key width, signed two's complement
	localparam int ACT_W      = 2;   // action code width
	localparam int STAT_W     = 2;   // status code width
	localparam int SLOT_W     = 10;  // reported slot number width
	localparam int CFG_W      = 11;  // table_size register width
	localparam int OUT_DATA_W = 16;  // slot_index padded to whole bytes

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1021;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	typedef logic [KEY_W-1:0] key_t;

endpackage

/* rtl/qph_ram.sv */
// ----------------------------------------------------------------------------
// qph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/qph_mod.sv */
// ----------------------------------------------------------------------------
// qph_mod
// Iterative restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module qph_mod
	import qph_pkg::*;
#(
	parameter int DIV_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  key_t             dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] remainder
);

	localparam int CNT_W = $clog2(KEY_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	key_t             dvd_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   rem_next;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[KEY_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial - {1'b0, divisor};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= DIV_W'(rem_next);
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* rtl/quadratic_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table of signed keys with quadratic probing.
// ----------------------------------------------------------------------------
// One request at a time: insert, search or delete of a 32-bit signed key.
// The home slot is |key| mod S, S being table_size clamped to 1..TABLE_DEPTH,
// and probe p visits (home + p*p) mod S. Key zero marks an empty slot, so a
// request on key zero (or with an unknown action) answers "not found" and
// changes nothing. The home slot comes from a bit-serial remainder unit, and
// each probe is then a RAM read followed by a compare/write; a request makes
// at most S probes before the result is handed over. Requests on key zero
// (or with an unknown action) skip the remainder and answer in the next cycle.
// After reset the block sweeps the slot RAM to empty and takes no request
// until done; table_size writes are taken at any time and must only come
// while idle.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
	import qph_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration: table_size
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [KEY_W-1:0]      s_tdata,   // [31:0] key
	input  logic [ACT_W-1:0]      s_tuser,   // [1:0] action
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [9:0] slot_index, rest zero
	output logic [STAT_W-1:0]     m_tuser    // [1:0] status
);

	localparam int AW = $clog2(TABLE_DEPTH);      // slot address width
	localparam int EW = $clog2(TABLE_DEPTH + 1);  // effective size width

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  tsize_q;
	logic [AW-1:0]     clr_q;
	logic [ACT_W-1:0]  act_q;
	key_t              key_q;
	logic [AW-1:0]     idx_q;     // current probe slot
	logic [AW-1:0]     dlt_q;     // (2p+1) mod S, step to the next probe
	logic [EW-1:0]     prb_q;     // probes done so far
	logic [STAT_W-1:0] stat_q;
	logic [SLOT_W-1:0] slot_q;

	logic [EW-1:0]     size;
	key_t              mag;
	logic              accept;
	logic              trivial;
	logic              div_done;
	logic [EW-1:0]     div_rem;
	key_t              rd_data;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	key_t              ram_wdata;
	logic [EW:0]       idx_sum;
	logic [AW-1:0]     idx_next;
	logic [EW:0]       dlt_sum;
	logic [AW-1:0]     dlt_next;
	logic              last_probe;
	logic              slot_empty;
	logic              key_hit;

	// effective size: zero means one slot, saturate at the depth
	always_comb begin
		if (tsize_q == '0) begin
			size = EW'(1);
		end else if (32'(tsize_q) > 32'(TABLE_DEPTH)) begin
			size = EW'(TABLE_DEPTH);
		end else begin
			size = EW'(tsize_q);
		end
	end

	// |key|; the most negative key wraps to 2^31, as wanted
	assign mag = s_tdata[KEY_W-1] ? (~s_tdata + 1'b1) : s_tdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign trivial   = (s_tdata == '0) || (s_tuser != ACT_INSERT &&
	                   s_tuser != ACT_SEARCH && s_tuser != ACT_DELETE);

	qph_mod #(
		.DIV_W (EW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && !trivial),
		.dividend  (mag),
		.divisor   (size),
		.done      (div_done),
		.remainder (div_rem)
	);

	// next probe: idx + (2p+1), then step + 2, each wrapped by one subtract
	always_comb begin
		idx_sum = (EW+1)'(idx_q) + (EW+1)'(dlt_q);
		if (idx_sum >= (EW+1)'(size)) begin
			idx_sum = idx_sum - (EW+1)'(size);
		end
		idx_next = AW'(idx_sum);
		dlt_sum = (EW+1)'(dlt_q) + (EW+1)'(2);
		if (dlt_sum >= (EW+1)'(size)) begin
			dlt_sum = dlt_sum - (EW+1)'(size);
		end
		dlt_next = AW'(dlt_sum);
	end

	assign last_probe = (prb_q == size - 1'b1);
	assign slot_empty = (rd_data == '0);
	assign key_hit    = (rd_data == key_q);

	// slot RAM writes: reset sweep, insert into empty slot, delete on hit
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = key_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_CHECK) begin
			if (act_q == ACT_INSERT) begin
				ram_we = slot_empty;
			end else if (act_q == ACT_DELETE) begin
				ram_we    = !slot_empty && key_hit;
				ram_wdata = '0;
			end
		end
	end

	qph_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tsize_q <= CFG_RESET;
			clr_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tsize_q <= cfg_data;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= trivial ? S_OUT : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (act_q == ACT_INSERT) begin
						if (slot_empty || last_probe) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_READ;
						end
					end else if (slot_empty || key_hit || last_probe) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and probe datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q  <= s_tuser;
				key_q  <= s_tdata;
				slot_q <= '0;
				// an insert stays "full" if no empty slot turns up
				if (s_tuser == ACT_INSERT && !trivial) begin
					stat_q <= STAT_FULL;
				end else begin
					stat_q <= STAT_MISS;
				end
			end
			S_DIV: begin
				idx_q <= AW'(div_rem);
				prb_q <= '0;
				dlt_q <= (size == EW'(1)) ? AW'(0) : AW'(1);
			end
			S_CHECK: begin
				idx_q <= idx_next;
				dlt_q <= dlt_next;
				prb_q <= prb_q + 1'b1;
				if (act_q == ACT_INSERT) begin
					if (slot_empty) begin
						stat_q <= STAT_DONE;
						slot_q <= SLOT_W'(idx_q);
					end
				end else if (!slot_empty && key_hit) begin
					stat_q <= (act_q == ACT_DELETE) ? STAT_DONE : STAT_FOUND;
					slot_q <= SLOT_W'(idx_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = OUT_DATA_W'(slot_q);
	assign m_tuser  = stat_q;

endmodule
